// ===== hw/rtl/utf8d_pkg.sv =====
// Shared types, byte constants and helpers for the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int CpWidth    = 31;
    localparam int CountWidth = 16;
    localparam int CfgWidth   = 16;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_OUTPUT_MODE = 1'b0,
        CFG_MAX_CHARS   = 1'b1
    } utf8d_cfg_idx_t;

    // Output modes
    localparam logic MODE_UCS2 = 1'b0;
    localparam logic MODE_UCS4 = 1'b1;

    // Lead byte boundaries
    localparam logic [7:0] BYTE_CONT  = 8'h80;
    localparam logic [7:0] LEAD_MIN   = 8'hC2;
    localparam logic [7:0] LEAD_3B    = 8'hE0;
    localparam logic [7:0] LEAD_4B    = 8'hF0;
    localparam logic [7:0] LEAD_5B    = 8'hF8;
    localparam logic [7:0] LEAD_6B    = 8'hFC;
    localparam logic [7:0] LEAD_BAD   = 8'hFE;

    // Second-byte minimums against overlong forms
    localparam logic [7:0] MIN2_3B    = 8'hA0;
    localparam logic [7:0] MIN2_4B    = 8'h90;
    localparam logic [7:0] MIN2_5B    = 8'h88;
    localparam logic [7:0] MIN2_6B    = 8'h84;
    localparam logic [7:0] CONT_SPAN  = 8'h40;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } utf8d_beat_t;

    typedef struct packed {
        logic [CpWidth-1:0]    code_point;
        logic                  has_char;
        logic                  end_of_string;
        logic [CountWidth-1:0] char_count;
    } utf8d_result_t;

    function automatic logic [7:0] second_min(input logic [7:0] lead);
        logic [7:0] m;
        m = BYTE_CONT;
        if (lead == LEAD_3B)      m = MIN2_3B;
        else if (lead == LEAD_4B) m = MIN2_4B;
        else if (lead == LEAD_5B) m = MIN2_5B;
        else if (lead == LEAD_6B) m = MIN2_6B;
        return m;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b ^ BYTE_CONT) < CONT_SPAN;
    endfunction

endpackage

// ===== hw/rtl/utf8d_in_reg.sv =====
// Input register stage holding one byte beat ahead of the decoder.
module utf8d_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  utf8d_pkg::utf8d_beat_t s_beat,
    input  logic                 pop,
    output logic                 valid,
    output utf8d_pkg::utf8d_beat_t beat
);
    import utf8d_pkg::*;

    logic        valid_reg;
    utf8d_beat_t beat_reg;

    assign s_ready = !valid_reg || pop;
    assign valid   = valid_reg;
    assign beat    = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

endmodule

// ===== hw/rtl/utf8d_core.sv =====
// Decoder state and the per-byte next-state and result logic.
module utf8d_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             commit,
    input  utf8d_pkg::utf8d_beat_t           beat,
    input  logic                             output_mode,
    input  logic [utf8d_pkg::CountWidth-1:0] max_chars,
    output utf8d_pkg::utf8d_result_t         result
);
    import utf8d_pkg::*;

    logic [CpWidth-1:0]    partial_reg, partial_next;
    logic [2:0]            left_reg, left_next;
    logic [7:0]            lead_reg, lead_next;
    logic                  await_reg, await_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic                  done_reg, done_next;

    always_comb begin
        logic [7:0]         b;
        logic [CpWidth-1:0] shifted;
        logic [CpWidth-1:0] cp;
        logic [2:0]         left_dec;
        logic               got;
        logic               as_lead;
        logic               has;
        logic               ends;

        b            = beat.data_byte;
        partial_next = partial_reg;
        left_next    = left_reg;
        lead_next    = lead_reg;
        await_next   = await_reg;
        count_next   = count_reg;
        got          = 1'b0;
        as_lead      = 1'b0;
        cp           = '0;
        has          = 1'b0;

        // Start a fresh string after an end
        if (done_reg) begin
            partial_next = '0;
            left_next    = '0;
            lead_next    = '0;
            await_next   = 1'b0;
            count_next   = '0;
        end

        shifted  = {partial_next[CpWidth-7:0], b[5:0]};
        left_dec = left_next - 3'd1;

        if (b != 8'h00) begin
            if (left_next != 3'd0) begin
                if (is_cont(b)) begin
                    if (await_next && (b < second_min(lead_next))) begin
                        // Overlong: drop sequence, consume the byte
                        partial_next = '0;
                        left_next    = '0;
                        lead_next    = '0;
                        await_next   = 1'b0;
                    end else if (left_dec == 3'd0) begin
                        got          = 1'b1;
                        cp           = shifted;
                        partial_next = '0;
                        left_next    = '0;
                        lead_next    = '0;
                        await_next   = 1'b0;
                    end else begin
                        partial_next = shifted;
                        left_next    = left_dec;
                        await_next   = 1'b0;
                    end
                end else begin
                    // Broken sequence: drop and re-examine as a lead
                    partial_next = '0;
                    left_next    = '0;
                    lead_next    = '0;
                    await_next   = 1'b0;
                    as_lead      = 1'b1;
                end
            end else begin
                as_lead = 1'b1;
            end

            if (as_lead) begin
                if (b < BYTE_CONT) begin
                    got = 1'b1;
                    cp  = {{(CpWidth-8){1'b0}}, b};
                end else if (b inside {[LEAD_MIN:LEAD_3B-8'd1]}) begin
                    partial_next = {{(CpWidth-5){1'b0}}, b[4:0]};
                    left_next    = 3'd1;
                    lead_next    = b;
                    await_next   = 1'b1;
                end else if (b inside {[LEAD_3B:LEAD_4B-8'd1]}) begin
                    partial_next = {{(CpWidth-4){1'b0}}, b[3:0]};
                    left_next    = 3'd2;
                    lead_next    = b;
                    await_next   = 1'b1;
                end else if (output_mode == MODE_UCS4) begin
                    if (b inside {[LEAD_4B:LEAD_5B-8'd1]}) begin
                        partial_next = {{(CpWidth-3){1'b0}}, b[2:0]};
                        left_next    = 3'd3;
                        lead_next    = b;
                        await_next   = 1'b1;
                    end else if (b inside {[LEAD_5B:LEAD_6B-8'd1]}) begin
                        partial_next = {{(CpWidth-2){1'b0}}, b[1:0]};
                        left_next    = 3'd4;
                        lead_next    = b;
                        await_next   = 1'b1;
                    end else if (b inside {[LEAD_6B:LEAD_BAD-8'd1]}) begin
                        partial_next = {{(CpWidth-1){1'b0}}, b[0]};
                        left_next    = 3'd5;
                        lead_next    = b;
                        await_next   = 1'b1;
                    end
                end
            end

            if (got && (count_next < max_chars)) begin
                has        = 1'b1;
                count_next = count_next + 16'd1;
            end
        end

        ends = (b == 8'h00) || beat.last_byte;
        if (ends) begin
            partial_next = '0;
            left_next    = '0;
            lead_next    = '0;
            await_next   = 1'b0;
        end
        done_next = ends;

        result.code_point    = has ? cp : '0;
        result.has_char      = has;
        result.end_of_string = ends;
        result.char_count    = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            left_reg    <= '0;
            lead_reg    <= '0;
            await_reg   <= 1'b0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end else if (commit) begin
            partial_reg <= partial_next;
            left_reg    <= left_next;
            lead_reg    <= lead_next;
            await_reg   <= await_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
        end
    end

    a_open_seq_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg != 3'd0 |-> lead_reg >= LEAD_MIN)
        else $error("open sequence without a valid lead byte");

    a_done_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (left_reg == 3'd0 && !await_reg))
        else $error("sequence left open after end of string");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !done_reg) |=> (count_reg == $past(count_reg) ||
                                   count_reg == 16'($past(count_reg) + 16'd1)))
        else $error("character count jumped");

endmodule

// ===== hw/rtl/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder top level: config registers, input stage, decoder, result register.
// A byte taken into the input register is decoded between the input and result registers;
// throughput is one byte per cycle while m_ready does not stall the result register.
// Reset: synchronous active-low aresetn empties both stages, closes any open sequence,
// clears the count and sets output_mode to UCS2 and max_chars to 65535.
module utf8_stream_decoder_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [0:0]                       cfg_index,
    input  logic [utf8d_pkg::CfgWidth-1:0]   cfg_wdata,
    // byte input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_last_byte,
    // decoded results
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [utf8d_pkg::CpWidth-1:0]    m_code_point,
    output logic                             m_has_char,
    output logic                             m_end_of_string,
    output logic [utf8d_pkg::CountWidth-1:0] m_char_count
);
    import utf8d_pkg::*;

    logic                  mode_reg;
    logic [CountWidth-1:0] max_chars_reg;

    utf8d_beat_t   in_beat;
    utf8d_beat_t   held_beat;
    logic          held_valid;
    logic          advance;
    utf8d_result_t dec_result;

    logic          out_valid_reg;
    utf8d_result_t out_reg;

    // Config registers: the user writes them only while the block is idle; no check enforces it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_UCS2;
            max_chars_reg <= '1;
        end else if (cfg_wr_en) begin
            case (utf8d_cfg_idx_t'(cfg_index))
                CFG_OUTPUT_MODE: mode_reg      <= cfg_wdata[0];
                CFG_MAX_CHARS:   max_chars_reg <= cfg_wdata[CountWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_beat.data_byte = s_data_byte;
    assign in_beat.last_byte = s_last_byte;

    // Advance the held beat when the result register is free or being drained
    assign advance = held_valid && (!out_valid_reg || m_ready);

    utf8d_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_beat  (in_beat),
        .pop     (advance),
        .valid   (held_valid),
        .beat    (held_beat)
    );

    // Decode the held beat against the current state; commit on advance
    utf8d_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .commit      (advance),
        .beat        (held_beat),
        .output_mode (mode_reg),
        .max_chars   (max_chars_reg),
        .result      (dec_result)
    );

    // Result register: hold until the consumer takes the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= held_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= dec_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_code_point    = out_reg.code_point;
    assign m_has_char      = out_reg.has_char;
    assign m_end_of_string = out_reg.end_of_string;
    assign m_char_count    = out_reg.char_count;

endmodule
